### sv/assert_macros.svh
// Assertion macros shared by the page-fault counter RTL.
// No dependencies; the including module must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define LPFC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define LPFC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/lpfc_pkg.sv
// Package for the LRU page-fault counter: sizes, register map and shared types.
// No dependencies; used by the interfaces, the RTL modules and the testbench.
`default_nettype none

package lpfc_pkg;

  localparam int unsigned FRAME_DEPTH = 16;
  localparam int unsigned PAGE_BITS   = 16;
  localparam int unsigned IDX_W       = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;

  localparam int unsigned IN_PAGE_W  = 16;
  localparam int unsigned OUT_PAGE_W = 16;
  localparam int unsigned COUNT_W    = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam int unsigned CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_CAPACITY = '0;

  typedef logic [PAGE_BITS-1:0] page_t;

  typedef struct packed {
    logic  step;
    logic  first;
    logic  hit;
    logic  evict;
    page_t page;
  } cell_ctrl_t;

  typedef struct packed {
    logic             step;
    logic             first;
    logic [IDX_W-1:0] cap_idx;
    page_t            page;
  } chain_req_t;

  typedef struct packed {
    logic  hit;
    logic  evict;
    page_t evict_page;
  } chain_rsp_t;

endpackage

`default_nettype wire

### sv/lpfc_if.sv
// Handshake interfaces for the reference channel and the result channel.
// Depends on lpfc_pkg for the field widths.
`default_nettype none

interface lpfc_in_if;
  logic                            valid;
  logic                            ready;
  logic [lpfc_pkg::IN_PAGE_W-1:0]  page_number;
  logic                            first_in_run;
  logic                            last_in_run;

  modport source (output valid, page_number, first_in_run, last_in_run, input ready);
  modport sink   (input valid, page_number, first_in_run, last_in_run, output ready);
endinterface

interface lpfc_out_if;
  logic                             valid;
  logic                             ready;
  logic                             fault;
  logic                             evicted_valid;
  logic [lpfc_pkg::OUT_PAGE_W-1:0]  evicted_page;
  logic [lpfc_pkg::COUNT_W-1:0]     fault_total;
  logic                             run_done;

  modport source (output valid, fault, evicted_valid, evicted_page, fault_total, run_done,
                  input ready);
  modport sink   (input valid, fault, evicted_valid, evicted_page, fault_total, run_done,
                  output ready);
endinterface

`default_nettype wire

### sv/lpfc_cell.sv
// One frame of the recency chain: a page register and its valid bit.
// Depends on lpfc_pkg for cell_ctrl_t and page_t.
`default_nettype none

module lpfc_cell (
  input  wire                   clk,
  input  wire                   rst_n,
  input  lpfc_pkg::cell_ctrl_t  ctrl,
  input  wire                   prev_valid,
  input  wire                   passed,
  input  lpfc_pkg::page_t       nxt_page,
  input  wire                   nxt_valid,
  output lpfc_pkg::page_t       page_o,
  output logic                  valid_o,
  output logic                  match_o
);

  lpfc_pkg::page_t page_r, page_nxt;
  logic            valid_r, valid_nxt;
  logic            v, shift, tail, fill;

  // A run start makes the whole chain look empty for this reference.
  assign v       = valid_r & ~ctrl.first;
  assign match_o = v & (page_r == ctrl.page);
  assign shift   = v & (ctrl.hit ? passed : ctrl.evict);
  assign tail    = v & ~nxt_valid;
  assign fill    = ~ctrl.hit & ~ctrl.evict & ~v & prev_valid;

  always_comb begin
    valid_nxt = v | fill;
    page_nxt  = page_r;
    if (shift) begin
      page_nxt = tail ? ctrl.page : nxt_page;
    end else if (fill) begin
      page_nxt = ctrl.page;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctrl.step) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      page_r <= page_nxt;
    end
  end

  assign page_o  = page_r;
  assign valid_o = valid_r;

endmodule

`default_nettype wire

### sv/lpfc_chain.sv
// Row of recency cells, least recent at cell 0, with the hit and eviction decision.
// Depends on lpfc_pkg, lpfc_cell and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module lpfc_chain (
  input  wire                   clk,
  input  wire                   rst_n,
  input  lpfc_pkg::chain_req_t  req,
  output lpfc_pkg::chain_rsp_t  rsp
);

  lpfc_pkg::page_t                  cell_page [lpfc_pkg::FRAME_DEPTH];
  logic [lpfc_pkg::FRAME_DEPTH-1:0] cell_valid;
  logic [lpfc_pkg::FRAME_DEPTH-1:0] cell_match;
  logic [lpfc_pkg::FRAME_DEPTH:0]   pass;
  lpfc_pkg::cell_ctrl_t             ctrl;
  logic                             hit, full;

  // The match flag ripples toward the most recent end; every occupied cell at or past
  // the hit takes its neighbor's page, and the most recent one takes the reference.
  assign pass[0] = 1'b0;
  assign hit     = pass[lpfc_pkg::FRAME_DEPTH];
  // Valid cells form a prefix, so the store is full when the frame at the
  // capacity limit holds a page.
  assign full    = cell_valid[req.cap_idx] & ~req.first;

  assign ctrl.step  = req.step;
  assign ctrl.first = req.first;
  assign ctrl.hit   = hit;
  assign ctrl.evict = ~hit & full;
  assign ctrl.page  = req.page;

  for (genvar i = 0; i < lpfc_pkg::FRAME_DEPTH; i++) begin : g_cell
    logic            prev_v;
    logic            nv;
    lpfc_pkg::page_t np;

    assign pass[i+1] = pass[i] | cell_match[i];

    if (i == 0) begin : g_head
      assign prev_v = 1'b1;
    end else begin : g_body
      assign prev_v = cell_valid[i-1] & ~req.first;
    end

    if (i == lpfc_pkg::FRAME_DEPTH - 1) begin : g_end
      assign nv = 1'b0;
      assign np = '0;
    end else begin : g_mid
      assign nv = cell_valid[i+1];
      assign np = cell_page[i+1];
    end

    lpfc_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .prev_valid (prev_v),
      .passed     (pass[i+1]),
      .nxt_page   (np),
      .nxt_valid  (nv),
      .page_o     (cell_page[i]),
      .valid_o    (cell_valid[i]),
      .match_o    (cell_match[i])
    );
  end

  assign rsp.hit        = hit;
  assign rsp.evict      = ctrl.evict;
  assign rsp.evict_page = cell_page[0];

  // Resident pages are unique, so at most one frame matches.
  `LPFC_ASSERT(a_single_match, $onehot0(cell_match), "more than one frame matched the page")
  // Occupied frames always form a prefix of the chain.
  `LPFC_ASSERT(a_valid_prefix, ((cell_valid & (cell_valid + 1'b1)) == '0),
    "occupied frames are not contiguous from the least recent end")
  // A hit only reorders pages; occupancy stays the same.
  `LPFC_ASSERT(a_hit_keeps_occupancy, (req.step && hit) |=> (cell_valid == $past(cell_valid)),
    "a hit changed the set of occupied frames")

endmodule

`default_nettype wire

### sv/lru_page_fault_counter_core.sv
// Top level of the LRU page-fault counter: handshakes, capacity register,
// fault count and result register. Depends on lpfc_pkg, lpfc_if, lpfc_chain.
//
// The block keeps up to FRAME_DEPTH resident pages in a chain of frame
// cells ordered from least to most recently used, and takes one page
// reference per item. Every frame compares its page with the reference in
// parallel, so each item is decided combinationally and its result is
// held in an output register from the next cycle on. A new item is taken in
// the cycle in which the previous result leaves or later, so items follow
// back to back while the receiver keeps up, and a result that waits holds
// off the input. The limit is the match, shift and fault count update
// through the chain.
// A hit moves the page to the most recent end. A miss raises the fault
// count, which saturates at its maximum, and either fills the next free
// frame or, with capacity frames occupied, evicts the least recent page and
// reports it. Setting first_in_run empties the store and clears the count
// before that reference is handled, and last_in_run is echoed as run_done.
// Capacity is written through the APB port at byte address 0; zero acts as
// one and values above FRAME_DEPTH act as FRAME_DEPTH. Lowering it while
// more frames are occupied does not drop pages: each later miss evicts one
// page and adds one. Write capacity only while no item is in flight.
`default_nettype none
`include "assert_macros.svh"

module lru_page_fault_counter_core (
  input  wire                              clk,
  input  wire                              rst_n,
  lpfc_in_if.sink                          in_ch,
  lpfc_out_if.source                       out_ch,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [lpfc_pkg::PADDR_W-1:0]     paddr,
  input  wire  [lpfc_pkg::PDATA_W-1:0]     pwdata,
  output logic [lpfc_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready
);

  logic [lpfc_pkg::CAP_W-1:0]   cap_r;
  logic [lpfc_pkg::CAP_W-1:0]   cap_m1;
  logic [lpfc_pkg::IDX_W-1:0]   cap_idx;
  logic [lpfc_pkg::COUNT_W-1:0] cnt_r, cnt_base, cnt_nxt;
  logic                         reg_sel, cfg_wr;
  logic                         in_ready, step;
  lpfc_pkg::chain_req_t         req;
  lpfc_pkg::chain_rsp_t         rsp;

  logic                            out_valid_r;
  logic                            out_fault_r;
  logic                            out_ev_valid_r;
  logic [lpfc_pkg::OUT_PAGE_W-1:0] out_ev_page_r;
  logic [lpfc_pkg::COUNT_W-1:0]    out_total_r;
  logic                            out_done_r;

  // Configuration port. Every access completes in its access cycle.
  assign reg_sel = (paddr[lpfc_pkg::PADDR_W-1:2] == lpfc_pkg::REG_CAPACITY);
  assign cfg_wr  = psel & penable & pwrite & reg_sel;
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? lpfc_pkg::PDATA_W'(cap_r) : '0;

  // Clamp the capacity into 1..FRAME_DEPTH and turn it into a frame index.
  assign cap_m1  = (cap_r == '0) ? '0 : cap_r - 1'b1;
  assign cap_idx = (32'(cap_m1) >= lpfc_pkg::FRAME_DEPTH) ?
                   lpfc_pkg::IDX_W'(lpfc_pkg::FRAME_DEPTH - 1) :
                   lpfc_pkg::IDX_W'(cap_m1);

  // The output register frees up as soon as its result is taken.
  assign in_ready    = ~out_valid_r | out_ch.ready;
  assign in_ch.ready = in_ready;
  assign step        = in_ch.valid & in_ready;

  assign req.step    = step;
  assign req.first   = in_ch.first_in_run;
  assign req.cap_idx = cap_idx;
  assign req.page    = lpfc_pkg::PAGE_BITS'(in_ch.page_number);

  lpfc_chain u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  // Fault count: cleared by a run start, then saturating on each miss.
  always_comb begin
    cnt_base = in_ch.first_in_run ? '0 : cnt_r;
    cnt_nxt  = cnt_base;
    if (!rsp.hit && (cnt_base != lpfc_pkg::COUNT_MAX)) begin
      cnt_nxt = cnt_base + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= lpfc_pkg::CAP_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        cap_r <= pwdata[lpfc_pkg::CAP_W-1:0];
      end
      if (step) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_fault_r    <= ~rsp.hit;
      out_ev_valid_r <= rsp.evict;
      out_ev_page_r  <= rsp.evict ? lpfc_pkg::OUT_PAGE_W'(rsp.evict_page) : '0;
      out_total_r    <= cnt_nxt;
      out_done_r     <= in_ch.last_in_run;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.fault         = out_fault_r;
  assign out_ch.evicted_valid = out_ev_valid_r;
  assign out_ch.evicted_page  = out_ev_page_r;
  assign out_ch.fault_total   = out_total_r;
  assign out_ch.run_done      = out_done_r;

  // A miss within a run that is not yet saturated advances the count by one.
  `LPFC_ASSERT(a_count_step,
    (step && !in_ch.first_in_run && !rsp.hit && cnt_r != lpfc_pkg::COUNT_MAX) |=>
    (cnt_r == $past(cnt_r) + 1'b1), "fault count did not advance on a miss")
  // An eviction is only ever reported together with a fault.
  `LPFC_ASSERT(a_evict_is_fault, (out_valid_r && out_ev_valid_r) |-> out_fault_r,
    "eviction reported on a hit")

endmodule

`default_nettype wire

### verif/tb.sv
// Self-checking testbench for lru_page_fault_counter_core: directed table, random runs,
// capacity sweeps over the APB port and a back-to-back one-frame miss stretch.
// Depends on lpfc_pkg, the lpfc_in_if/lpfc_out_if interfaces and the core RTL.

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD = 10;
  // Longest quiet stretch of a correct run is the receiver hold-off plus one item's
  // worth of sender gap and receiver stall; this is many times that.
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  // Length of the back-to-back miss stretch with a single frame.
  localparam int MISS_REFS = 30;

  // One page reference as it travels on the input channel.
  typedef struct packed {
    logic [lpfc_pkg::IN_PAGE_W-1:0] page;
    logic                           first;
    logic                           last;
  } page_ref_t;

  // One result item as it appears on the output channel.
  typedef struct packed {
    logic                            fault;
    logic                            evicted_valid;
    logic [lpfc_pkg::OUT_PAGE_W-1:0] evicted_page;
    logic [lpfc_pkg::COUNT_W-1:0]    fault_total;
    logic                            run_done;
  } ref_outcome_t;

  // A row of the directed table: an optional capacity write ahead of the item,
  // the item itself, and a hand-written outcome where one is obvious.
  typedef struct packed {
    bit                           set_cap;
    logic [lpfc_pkg::PDATA_W-1:0] cap_word;
    page_ref_t                    access;
    bit                           typed;
    ref_outcome_t                 want;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [lpfc_pkg::PADDR_W-1:0] paddr;
  logic [lpfc_pkg::PDATA_W-1:0] pwdata;
  logic [lpfc_pkg::PDATA_W-1:0] prdata;
  logic                         pready;

  lpfc_in_if  ref_ch ();
  lpfc_out_if res_ch ();

  lru_page_fault_counter_core uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (ref_ch),
    .out_ch  (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Shared knobs: idle_on lets both sides insert random gaps; hold_req asks the
  // result side for one long hold-off so the core backs up and stalls its input.
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;

  int unsigned  mismatch_count = 0;
  int unsigned  quiet_cycles = 0;
  ref_outcome_t pending_results[$];
  directed_row_t directed_rows[$];
  logic [lpfc_pkg::IN_PAGE_W-1:0] hot_pages[$];

  // Predicted LRU state: slot 0 is the least recently used page, and the
  // occupied slots always form a prefix of length frames_used.
  logic [lpfc_pkg::PAGE_BITS-1:0] lru_frames[lpfc_pkg::FRAME_DEPTH];
  int                             frames_used = 0;
  logic [lpfc_pkg::COUNT_W-1:0]   fault_count = '0;
  logic [lpfc_pkg::CAP_W-1:0]     capacity_mirror = lpfc_pkg::CAP_RESET;

  // Works out the result of one page reference and advances the predicted state.
  function automatic ref_outcome_t lru_predict(page_ref_t r);
    ref_outcome_t o;
    int cap_eff;
    int hit_at;
    int drop_at;
    o = '0;
    hit_at = -1;
    drop_at = -1;
    // Capacity zero behaves as one frame, anything above the built depth as the depth.
    cap_eff = int'(capacity_mirror);
    if (cap_eff < 1) cap_eff = 1;
    if (cap_eff > lpfc_pkg::FRAME_DEPTH) cap_eff = lpfc_pkg::FRAME_DEPTH;
    if (r.first) begin
      frames_used = 0;
      fault_count = '0;
    end
    // Hits are searched among every resident page, even beyond a lowered capacity.
    for (int i = 0; i < frames_used; i++) begin
      if (hit_at < 0 && lru_frames[i] == r.page[lpfc_pkg::PAGE_BITS-1:0]) hit_at = i;
    end
    if (hit_at >= 0) begin
      drop_at = hit_at;
    end else begin
      o.fault = 1'b1;
      if (fault_count != lpfc_pkg::COUNT_MAX) fault_count = fault_count + 1'b1;
      if (frames_used < cap_eff) begin
        frames_used++;
      end else begin
        // Full (or over-full after a capacity cut): exactly one page leaves.
        o.evicted_valid = 1'b1;
        o.evicted_page = lru_frames[0];
        drop_at = 0;
      end
    end
    if (drop_at >= 0) begin
      for (int i = drop_at; i + 1 < frames_used; i++) lru_frames[i] = lru_frames[i + 1];
    end
    lru_frames[frames_used - 1] = r.page[lpfc_pkg::PAGE_BITS-1:0];
    o.fault_total = fault_count;
    o.run_done = r.last;
    return o;
  endfunction

  function automatic string outcome_str(ref_outcome_t o);
    return $sformatf("fault=%0b evicted=%0b page=%04h total=%0d done=%0b",
                     o.fault, o.evicted_valid, o.evicted_page, o.fault_total, o.run_done);
  endfunction

  task automatic flag_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t ERROR: %s", $time, what);
  endtask

  function automatic void add_row(bit set_cap, logic [lpfc_pkg::PDATA_W-1:0] cap_word,
                                  logic [lpfc_pkg::IN_PAGE_W-1:0] page, bit first, bit last,
                                  bit typed, bit fault, bit ev,
                                  logic [lpfc_pkg::OUT_PAGE_W-1:0] ev_page,
                                  logic [lpfc_pkg::COUNT_W-1:0] total, bit done);
    directed_rows.push_back({set_cap, cap_word, page, first, last, typed,
                             fault, ev, ev_page, total, done});
  endfunction

  // Picks a working set of pages; the extremes show up now and then.
  function automatic void fill_hot(int n);
    hot_pages.delete();
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 7))
        0:       hot_pages.push_back('0);
        1:       hot_pages.push_back('1);
        default: hot_pages.push_back(lpfc_pkg::IN_PAGE_W'($urandom));
      endcase
    end
  endfunction

  // Offers one item, starting and ending at a falling edge. The prediction is
  // made at the accepting edge; a typed outcome from the table replaces it.
  task automatic send_ref(page_ref_t r, bit typed, ref_outcome_t typed_want);
    int gap;
    ref_outcome_t predicted;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      ref_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    ref_ch.valid = 1'b1;
    ref_ch.page_number = r.page;
    ref_ch.first_in_run = r.first;
    ref_ch.last_in_run = r.last;
    do @(posedge clk); while (ref_ch.ready !== 1'b1);
    predicted = lru_predict(r);
    pending_results.push_back(typed ? typed_want : predicted);
    @(negedge clk);
  endtask

  // Every item yields one result, so an empty expectation queue means the core
  // is idle; an extra wait then covers the output register.
  task automatic wait_drained();
    ref_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Writes the capacity register while idle, then reads it back.
  task automatic cap_write(logic [lpfc_pkg::PDATA_W-1:0] word);
    wait_drained();
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {lpfc_pkg::REG_CAPACITY, 2'b00};
    pwdata = word;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    capacity_mirror = word[lpfc_pkg::CAP_W-1:0];
    @(negedge clk);
    pwrite = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== lpfc_pkg::PDATA_W'(word[lpfc_pkg::CAP_W-1:0]))
      flag_mismatch($sformatf("capacity read back %h, expected %h", prdata,
                              word[lpfc_pkg::CAP_W-1:0]));
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  // Random traffic shaped as runs: a first flag, a random length of references
  // drawn mostly from the working set, and a last flag on the final one. About
  // one item in eight is noise: a stray flag or a page from the full range.
  task automatic run_random(int n_refs, bit carry_over);
    page_ref_t r;
    int run_left;
    run_left = carry_over ? $urandom_range(10, 60) : 0;
    repeat (n_refs) begin
      r.first = (run_left == 0);
      if (run_left == 0) run_left = $urandom_range(1, 60);
      r.last = (run_left == 1);
      run_left--;
      if ($urandom_range(0, 99) < 12) begin
        r.first = r.first | ($urandom_range(0, 7) == 0);
        r.last = 1'($urandom_range(0, 1));
        r.page = lpfc_pkg::IN_PAGE_W'($urandom);
      end else begin
        r.page = hot_pages[$urandom_range(0, hot_pages.size() - 1)];
      end
      send_ref(r, 1'b0, '0);
    end
  endtask

  // Result side: a random stall before each item while idle_on is set, plus the single
  // long hold-off when asked. Ready changes only at falling edges.
  initial begin : result_sink
    int stall;
    res_ch.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        res_ch.ready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      stall = idle_on ? $urandom_range(0, 7) : 0;
      if (stall != 0) begin
        res_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      res_ch.ready = 1'b1;
      do @(posedge clk); while (res_ch.valid !== 1'b1);
      @(negedge clk);
    end
  end

  // Each accepted result is checked against the oldest expectation.
  always @(posedge clk) begin : result_check
    ref_outcome_t want;
    ref_outcome_t got;
    if (rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      got = {res_ch.fault, res_ch.evicted_valid, res_ch.evicted_page,
             res_ch.fault_total, res_ch.run_done};
      if (pending_results.size() == 0) begin
        flag_mismatch({"result with nothing expected: ", outcome_str(got)});
      end else begin
        want = pending_results.pop_front();
        if (got !== want)
          flag_mismatch({"expected ", outcome_str(want), ", got ", outcome_str(got)});
      end
    end
  end

  // Watchdog: consecutive cycles without any accepted item on either channel.
  always @(posedge clk) begin
    if ((ref_ch.valid === 1'b1 && ref_ch.ready === 1'b1) ||
        (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("lru_page_fault_counter_core verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    int phase_caps[11];
    int cap_eff;
    logic [lpfc_pkg::PDATA_W-1:0] word;
    logic [lpfc_pkg::IN_PAGE_W-1:0] alt_page;
    page_ref_t r;

    rst_n = 1'b0;
    ref_ch.valid = 1'b0;
    ref_ch.page_number = '0;
    ref_ch.first_in_run = 1'b0;
    ref_ch.last_in_run = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;

    // Directed table. At reset capacity (16): the first fault, a second page, a
    // hit, then single-bit pages until all frames are full, and a miss that must
    // evict the least recent page.
    add_row(1'b0, '0, 16'h0000, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 16'h0000, 16'd1, 1'b0);
    add_row(1'b0, '0, 16'hFFFF, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 16'h0000, 16'd2, 1'b0);
    add_row(1'b0, '0, 16'h0000, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 16'h0000, 16'd2, 1'b0);
    for (int i = 0; i < 14; i++)
      add_row(1'b0, '0, 16'h0001 << i, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, '0, '0, 1'b0);
    add_row(1'b0, '0, 16'h8000, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 16'hFFFF, 16'd17, 1'b0);
    add_row(1'b0, '0, 16'h0000, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, '0, '0, 1'b0);
    // One frame: fault, hit on the lone resident, then an eviction on every miss.
    add_row(1'b1, 32'h0000_0001, 16'h1234, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 16'h0000, 16'd1,
            1'b0);
    add_row(1'b0, '0, 16'h1234, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 16'h0000, 16'd1, 1'b0);
    add_row(1'b0, '0, 16'hEDCB, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 16'h1234, 16'd2, 1'b0);
    // Capacity zero acts as one frame; upper bus bits are ignored by the register.
    add_row(1'b1, 32'hFFFF_FFE0, 16'h5555, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 16'hEDCB, 16'd3,
            1'b0);
    // Capacity above the depth acts as the full depth, so the next miss finds room.
    add_row(1'b1, 32'h0000_001F, 16'hAAAA, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 16'h0000, 16'd4,
            1'b1);
    add_row(1'b1, 32'h0000_0011, 16'h0F0F, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 16'h0000, 16'd1,
            1'b1);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (directed_rows[k]) begin
      if (directed_rows[k].set_cap) cap_write(directed_rows[k].cap_word);
      send_ref(directed_rows[k].access, directed_rows[k].typed, directed_rows[k].want);
    end

    // Random phases over a sweep of capacities, the out-of-range ones included.
    // Every fourth phase runs with no idling on either side; one phase carries
    // the long receiver hold-off. Odd phases continue the state of the last one.
    phase_caps = '{16, 1, 5, 0, 12, 31, 2, 8, 17, 16, 9};
    foreach (phase_caps[p]) begin
      word = $urandom;
      word[lpfc_pkg::CAP_W-1:0] = lpfc_pkg::CAP_W'(phase_caps[p]);
      if ($urandom_range(0, 1) == 0) word[lpfc_pkg::PDATA_W-1:lpfc_pkg::CAP_W] = '0;
      cap_write(word);
      cap_eff = (phase_caps[p] < 1) ? 1 :
                (phase_caps[p] > lpfc_pkg::FRAME_DEPTH) ? lpfc_pkg::FRAME_DEPTH
                                                        : phase_caps[p];
      fill_hot(cap_eff + $urandom_range(0, 6));
      idle_on = (p % 4 != 2);
      if (p == 3) hold_req = 1'b1;
      run_random(160, 1'(p % 2));
    end

    // Capacity cut below occupancy: fill all sixteen frames with distinct pages,
    // lower the capacity to three, and carry the run on from that state so the
    // old residents still hit and each miss swaps out exactly one page.
    idle_on = 1'b1;
    cap_write(32'h0000_0010);
    hot_pages.delete();
    for (int i = 0; i < lpfc_pkg::FRAME_DEPTH; i++) begin
      r.page = {12'($urandom), 4'(i)};
      r.first = (i == 0);
      r.last = 1'b0;
      hot_pages.push_back(r.page);
      send_ref(r, 1'b0, '0);
    end
    cap_write(32'h0000_0003);
    hot_pages.push_back(lpfc_pkg::IN_PAGE_W'($urandom));
    hot_pages.push_back(lpfc_pkg::IN_PAGE_W'($urandom));
    run_random(120, 1'b1);

    // One frame, no idling: two alternating pages miss on every item, so each
    // item after the first evicts the page of the one before. Three hits and one more miss follow.
    idle_on = 1'b0;
    cap_write(32'h0000_0001);
    alt_page = lpfc_pkg::IN_PAGE_W'($urandom);
    for (int i = 0; i < MISS_REFS; i++) begin
      r.page = i[0] ? ~alt_page : alt_page;
      r.first = (i == 0);
      r.last = 1'b0;
      send_ref(r, 1'b0, '0);
    end
    r.first = 1'b0;
    r.page = ((MISS_REFS - 1) % 2 == 1) ? ~alt_page : alt_page;
    repeat (3) send_ref(r, 1'b0, '0);
    r.page = ~r.page;
    r.last = 1'b1;
    send_ref(r, 1'b0, '0);

    // Let every outstanding result arrive, then allow for the output register.
    ref_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("lru_page_fault_counter_core verification clean");
    end else begin
      $display("lru_page_fault_counter_core verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/lpfc_pkg.sv
sv/lpfc_if.sv
sv/lpfc_cell.sv
sv/lpfc_chain.sv
sv/lru_page_fault_counter_core.sv
verif/tb.sv
